// ===== sv/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types, constants and arithmetic helpers for the detection candidate
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

   // feature layout
   localparam int COORD_COUNT = 4;
   localparam int V8_FIRST    = 4;   // first class score, no objectness
   localparam int V5_FIRST    = 5;   // first class score after objectness
   localparam int SSD_FIRST_C = 1;   // first non-background class in ssd

   localparam int FEAT_W  = 24;
   localparam int SCALE_W = 32;
   localparam int THR_W   = 13;
   localparam int CNT_REG_W = 9;
   localparam int OBJ_PROD_W = 2 * FEAT_W;
   localparam int PROD_W  = FEAT_W + SCALE_W + 1;
   localparam int BOX_W   = PROD_W + 2;
   localparam int OUT_W   = 16;
   localparam int CLASS_OUT_W = 8;

   localparam int FRAC_LO = 28;
   localparam int FRAC_HI = 29;
   localparam logic signed [BOX_W-1:0] BIAS_LO = 59'sd268435455;
   localparam logic signed [BOX_W-1:0] BIAS_HI = 59'sd536870911;

   localparam logic signed [BOX_W-1:0] BOX_MAX = 59'sd32767;
   localparam logic signed [BOX_W-1:0] BOX_MIN = -59'sd32768;
   localparam logic signed [OBJ_PROD_W-1:0] SCORE_MAX = 48'sd8388607;
   localparam logic signed [OBJ_PROD_W-1:0] SCORE_MIN = -48'sd8388608;

   typedef enum logic [1:0] {
      MODE_V8   = 2'd0,
      MODE_V5   = 2'd1,
      MODE_SSD  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LAYOUT_MODE     = 3'd0,
      CSR_CLASS_COUNT     = 3'd1,
      CSR_SCORE_THRESHOLD = 3'd2,
      CSR_X_SCALE         = 3'd3,
      CSR_Y_SCALE         = 3'd4
   } csr_index_type;

   // what a feature does to the running argmax
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SEED,
      KIND_MAX
   } kind_type;

   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] w;
      logic signed [OUT_W-1:0] h;
   } box_type;

   // objectness * score, floor shift by 12, saturate to 24 bits
   function automatic logic signed [FEAT_W-1:0] sat_score(
      input logic signed [OBJ_PROD_W-1:0] prod
   );
      logic signed [OBJ_PROD_W-1:0] sh;
      sh = prod >>> 12;
      if (sh > SCORE_MAX) begin
         return SCORE_MAX[FEAT_W-1:0];
      end else if (sh < SCORE_MIN) begin
         return SCORE_MIN[FEAT_W-1:0];
      end
      return sh[FEAT_W-1:0];
   endfunction

   // divide by 2^28 or 2^29 rounding toward zero, saturate to 16 bits
   function automatic logic signed [OUT_W-1:0] trunc_sat16(
      input logic signed [BOX_W-1:0] v,
      input logic                    hi
   );
      logic signed [BOX_W-1:0] bias;
      logic signed [BOX_W-1:0] q;
      if (v < 0) begin
         bias = hi ? BIAS_HI : BIAS_LO;
      end else begin
         bias = '0;
      end
      q = hi ? ((v + bias) >>> FRAC_HI) : ((v + bias) >>> FRAC_LO);
      if (q > BOX_MAX) begin
         return BOX_MAX[OUT_W-1:0];
      end else if (q < BOX_MIN) begin
         return BOX_MIN[OUT_W-1:0];
      end
      return q[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/dcd_box.sv =====
// ----------------------------------------------------------------------------
// dcd_box
// Turns four scaled coordinate products into the integer box: corner and
// size for ssd, centre minus half size for yolo.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_box import dcd_pkg::*; (
   input  prod_type prod [COORD_COUNT],
   input  logic     is_ssd,
   output box_type  box
);

   logic signed [BOX_W-1:0] e0, e1, e2, e3;

   assign e0 = BOX_W'(prod[0]);
   assign e1 = BOX_W'(prod[1]);
   assign e2 = BOX_W'(prod[2]);
   assign e3 = BOX_W'(prod[3]);

   always_comb begin
      if (is_ssd) begin
         // prod order is y1, x1, y2, x2
         box.x = trunc_sat16(e1, 1'b0);
         box.y = trunc_sat16(e0, 1'b0);
         box.w = trunc_sat16(e3 - e1, 1'b0);
         box.h = trunc_sat16(e2 - e0, 1'b0);
      end else begin
         // prod order is cx, cy, w, h; edge = (2c - s) / 2
         box.x = trunc_sat16((e0 <<< 1) - e2, 1'b1);
         box.y = trunc_sat16((e1 <<< 1) - e3, 1'b1);
         box.w = trunc_sat16(e2, 1'b0);
         box.h = trunc_sat16(e3, 1'b0);
      end
   end

endmodule

`default_nettype wire

// ===== sv/detection_candidate_decoder.sv =====
// Throughput: one feature word per cycle, no gap between candidates, while rsp_ready holds;
// a pending result word holds the stream at a later candidate's last feature.
// Path: accepting a candidate's last feature loads the input register; then decode/
// objectness multiply, argmax and coordinate scaling, box combine into the output register.
// Reset: synchronous; clears the pipeline and candidate state and loads the
// register defaults (yolov8, 80 classes, threshold 0.5, unit scales).
// ----------------------------------------------------------------------------
// detection_candidate_decoder
// Streams one candidate's features, keeps a running argmax over class scores
// and emits one decoded, scaled and saturated box when the winner passes.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_candidate_decoder import dcd_pkg::*; #(
   parameter int MAX_CLASSES = 256
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [FEAT_W-1:0]       req_feature_value,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_box_x,
   output logic signed [OUT_W-1:0]        rsp_box_y,
   output logic signed [OUT_W-1:0]        rsp_box_width,
   output logic signed [OUT_W-1:0]        rsp_box_height,
   output logic [CLASS_OUT_W-1:0]         rsp_class_index,
   output logic signed [FEAT_W-1:0]       rsp_score,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [SCALE_W-1:0]             csr_data
);

   localparam int CLS_W = $clog2(MAX_CLASSES);
   localparam int CNT_W = $clog2(MAX_CLASSES + 1);
   localparam int POS_W = $clog2(MAX_CLASSES + V5_FIRST);

   // configuration
   mode_type              mode_ff;
   logic [CNT_REG_W-1:0]  class_count_ff;
   logic [THR_W-1:0]      thr_ff;
   logic [SCALE_W-1:0]    x_scale_ff;
   logic [SCALE_W-1:0]    y_scale_ff;

   logic                  is_v5, is_ssd;
   logic [CNT_W-1:0]      count_eff;
   logic [POS_W-1:0]      first_pos, last_pos;
   logic signed [FEAT_W-1:0] thr_s;

   // input register
   logic                  r_v_ff, r_v_in;
   logic signed [FEAT_W-1:0] r_val_ff;

   // candidate state
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic signed [FEAT_W-1:0] obj_ff, obj_in;
   logic signed [FEAT_W-1:0] coord_ff [COORD_COUNT];
   logic signed [FEAT_W-1:0] coord_in [COORD_COUNT];
   logic signed [FEAT_W-1:0] best_score_ff, best_score_in;
   logic [CLS_W-1:0]      best_cls_ff, best_cls_in;

   // decode stage
   logic                  p_v_ff, p_v_in;
   logic signed [FEAT_W-1:0] p_val_ff;
   logic signed [OBJ_PROD_W-1:0] p_prod_ff, p_prod_in;
   kind_type              p_kind_ff, p_kind_in;
   logic [CLS_W-1:0]      p_cls_ff, p_cls_in;
   logic                  p_last_ff, p_last_in;
   logic                  p_objok_ff, p_objok_in;
   logic signed [FEAT_W-1:0] p_coord_ff [COORD_COUNT];

   // result stage
   logic                  c_v_ff, c_v_in;
   prod_type              c_prod_ff [COORD_COUNT];
   prod_type              c_prod_in [COORD_COUNT];
   logic signed [FEAT_W-1:0] c_score_ff;
   logic [CLS_W-1:0]      c_cls_ff, c_cls_in;
   logic                  c_ok;

   // output register
   logic                  o_v_ff, o_v_in;
   box_type               o_box_ff, box;
   logic [CLS_W-1:0]      o_cls_ff;
   logic signed [FEAT_W-1:0] o_score_ff;

   // flow control
   logic                  o_load, c_free, p_fire, p_free, r_fire, r_free;

   logic [POS_W-1:0]      cls_off;
   logic                  pos_last;
   logic signed [FEAT_W-1:0] s_cur;
   logic signed [SCALE_W:0] scale_s [COORD_COUNT];

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_V8;
         class_count_ff <= 9'd80;
         thr_ff         <= 13'd2048;
         x_scale_ff     <= 32'd65536;
         y_scale_ff     <= 32'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LAYOUT_MODE:     mode_ff        <= mode_type'(csr_data[1:0]);
            CSR_CLASS_COUNT:     class_count_ff <= csr_data[CNT_REG_W-1:0];
            CSR_SCORE_THRESHOLD: thr_ff         <= csr_data[THR_W-1:0];
            CSR_X_SCALE:         x_scale_ff     <= csr_data;
            CSR_Y_SCALE:         y_scale_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign is_v5  = (mode_ff == MODE_V5);
   assign is_ssd = (mode_ff == MODE_SSD);
   assign thr_s  = $signed({{(FEAT_W-THR_W){1'b0}}, thr_ff});

   always_comb begin
      if (class_count_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (32'(class_count_ff) > MAX_CLASSES) begin
         count_eff = CNT_W'(MAX_CLASSES);
      end else begin
         count_eff = CNT_W'(class_count_ff);
      end
   end

   assign first_pos = is_v5 ? POS_W'(V5_FIRST) : POS_W'(V8_FIRST);
   assign last_pos  = first_pos + POS_W'(count_eff) - POS_W'(1);

   // ---------------------------------------------------------- flow control
   assign o_load    = c_v_ff && (!o_v_ff || rsp_ready);
   assign c_free    = !c_v_ff || o_load;
   assign p_fire    = p_v_ff && (!p_last_ff || c_free);
   assign p_free    = !p_v_ff || p_fire;
   assign r_fire    = r_v_ff && p_free;
   assign r_free    = !r_v_ff || r_fire;
   assign req_ready = r_free;

   assign r_v_in = (req_valid && req_ready) ? 1'b1 : (r_fire ? 1'b0 : r_v_ff);

   // ---------------------------------------------------------- decode stage
   assign cls_off  = pos_ff - first_pos;
   assign pos_last = (pos_ff >= last_pos);

   always_comb begin
      pos_in     = pos_ff;
      obj_in     = obj_ff;
      coord_in   = coord_ff;
      p_kind_in  = KIND_NONE;
      p_cls_in   = CLS_W'(cls_off);
      p_last_in  = pos_last;
      p_objok_in = !(is_v5 && (obj_ff < thr_s));
      p_prod_in  = obj_ff * r_val_ff;
      p_v_in     = r_fire ? 1'b1 : (p_fire ? 1'b0 : p_v_ff);
      if (r_fire) begin
         if (pos_ff < POS_W'(COORD_COUNT)) begin
            coord_in[pos_ff[1:0]] = r_val_ff;
         end else if (is_v5 && pos_ff == POS_W'(V8_FIRST)) begin
            obj_in = r_val_ff;
         end else if (pos_ff <= last_pos) begin
            if (!is_ssd) begin
               p_kind_in = KIND_MAX;
            end else if (cls_off == POS_W'(SSD_FIRST_C)) begin
               p_kind_in = KIND_SEED;
            end else if (cls_off > POS_W'(SSD_FIRST_C)) begin
               p_kind_in = KIND_MAX;
            end
         end
         if (pos_last) begin
            pos_in = '0;
            obj_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         pos_ff <= '0;
         obj_ff <= '0;
      end else begin
         r_v_ff <= r_v_in;
         p_v_ff <= p_v_in;
         pos_ff <= pos_in;
         obj_ff <= obj_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COORD_COUNT; i++) begin
            coord_ff[i] <= '0;
         end
      end else begin
         coord_ff <= coord_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         r_val_ff <= req_feature_value;
      end
      if (r_fire) begin
         p_val_ff   <= r_val_ff;
         p_prod_ff  <= p_prod_in;
         p_kind_ff  <= p_kind_in;
         p_cls_ff   <= p_cls_in;
         p_last_ff  <= p_last_in;
         p_objok_ff <= p_objok_in;
         p_coord_ff <= coord_ff;
      end
   end

   // ------------------------------------------------- argmax and scaling stage
   assign s_cur = is_v5 ? sat_score(p_prod_ff) : p_val_ff;

   always_comb begin
      best_score_in = best_score_ff;
      best_cls_in   = best_cls_ff;
      case (p_kind_ff)
         KIND_SEED: begin
            best_score_in = s_cur;
            best_cls_in   = CLS_W'(SSD_FIRST_C);
         end
         KIND_MAX: begin
            if (s_cur > best_score_ff) begin
               best_score_in = s_cur;
               best_cls_in   = p_cls_ff;
            end
         end
         default: ;
      endcase
   end

   // ssd: y1, x1, y2, x2; yolo: cx, cy, w, h
   assign scale_s[0] = $signed({1'b0, is_ssd ? y_scale_ff : x_scale_ff});
   assign scale_s[1] = $signed({1'b0, is_ssd ? x_scale_ff : y_scale_ff});
   assign scale_s[2] = $signed({1'b0, is_ssd ? y_scale_ff : x_scale_ff});
   assign scale_s[3] = $signed({1'b0, is_ssd ? x_scale_ff : y_scale_ff});

   always_comb begin
      for (int i = 0; i < COORD_COUNT; i++) begin
         c_prod_in[i] = PROD_W'(p_coord_ff[i]) * PROD_W'(scale_s[i]);
      end
   end

   assign c_cls_in = is_ssd ? (best_cls_in - CLS_W'(1)) : best_cls_in;
   assign c_ok     = (best_score_in >= thr_s) && p_objok_ff
                     && !(is_ssd && count_eff <= CNT_W'(1));

   always_comb begin
      c_v_in = c_v_ff;
      if (p_fire && p_last_ff) begin
         c_v_in = c_ok;   // a dropped candidate leaves no word
      end else if (o_load) begin
         c_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff        <= 1'b0;
         best_score_ff <= '0;
         best_cls_ff   <= '0;
      end else begin
         c_v_ff <= c_v_in;
         if (p_fire) begin
            if (p_last_ff) begin
               best_score_ff <= '0;
               best_cls_ff   <= '0;
            end else begin
               best_score_ff <= best_score_in;
               best_cls_ff   <= best_cls_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_fire && p_last_ff) begin
         c_prod_ff  <= c_prod_in;
         c_score_ff <= best_score_in;
         c_cls_ff   <= c_cls_in;
      end
   end

   // ---------------------------------------------------------- output stage
   dcd_box u_box (
      .prod   (c_prod_ff),
      .is_ssd (is_ssd),
      .box    (box)
   );

   assign o_v_in = o_load ? 1'b1 : ((o_v_ff && rsp_ready) ? 1'b0 : o_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_box_ff   <= box;
         o_cls_ff   <= c_cls_ff;
         o_score_ff <= c_score_ff;
      end
   end

   assign rsp_valid       = o_v_ff;
   assign rsp_box_x       = o_box_ff.x;
   assign rsp_box_y       = o_box_ff.y;
   assign rsp_box_width   = o_box_ff.w;
   assign rsp_box_height  = o_box_ff.h;
   assign rsp_class_index = CLASS_OUT_W'(o_cls_ff);
   assign rsp_score       = o_score_ff;

   // ------------------------------------------------------------ assertions
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(MAX_CLASSES + V5_FIRST))
      else $error("feature position beyond longest candidate");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      c_v_ff && !o_load |=> c_v_ff)
      else $error("pending result word lost");

   a_argmax_cleared: assert property (@(posedge clock) disable iff (reset)
      p_fire && p_last_ff |=> best_score_ff == '0 && best_cls_ff == '0)
      else $error("argmax not cleared after candidate");

   a_last_needs_room: assert property (@(posedge clock) disable iff (reset)
      p_fire && p_last_ff |-> c_free)
      else $error("candidate end overwrote pending result");

endmodule

`default_nettype wire
